### sv/kaf_pkg.sv
// Package for the angle fusion filter: register index constants and word width.
// No dependencies.
package kaf_pkg;
   localparam int WORD_W = 32;
   localparam logic [1:0] CSR_ANGLE_NOISE   = 2'd0;
   localparam logic [1:0] CSR_BIAS_NOISE    = 2'd1;
   localparam logic [1:0] CSR_MEASURE_NOISE = 2'd2;
   localparam logic [1:0] CSR_TIME_STEP     = 2'd3;
endpackage

### sv/kalman_angle_fusion_top.sv
// Top level of the angle fusion filter: sequencer, one shared multiplier,
// one shared adder and a serial divider. Depends on kaf_pkg.
//
// Usage: the req_ channel carries one word per IMU sample, measured_angle in
// tdata[31:0] and gyro_rate in tdata[63:32]. For each word the block runs one
// step of a two-state Kalman filter and offers one rsp_ word with
// fused_angle in [31:0] and fused_rate in [63:32].
// The csr_ port writes the four noise and time-step registers; write only
// while the block is idle.
// Each word passes through the sequencer steps and two gain divisions on the
// serial divider; with a zero innovation variance both gains are set to zero
// without a division. req_tready is low while a word is at work, so a new
// word is taken only once the last result has gone into the output register.
// When the receiver stalls, the result waits in the output register and a
// new word is taken meanwhile; the next result waits until it is taken.
// Reset (synchronous, active high) clears the estimates to zero, sets the
// covariance to identity and the registers to their defaults.
module kalman_angle_fusion_top import kaf_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // measured_angle [31:0], gyro_rate [63:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // fused_angle [31:0], fused_rate [63:32]
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [19:0] csr_wdata
);
   localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
   localparam int DIV_W = 32 + FRAC_BITS + 1;
   localparam int CNT_W = $clog2(DIV_W + 1);

   // Sequencer step codes
   localparam logic [4:0] S_IDLE = 5'd0,  S_RATE = 5'd1,  S_AMUL = 5'd2,  S_AADD = 5'd3,
                          S_D0A = 5'd4,   S_D0B = 5'd5,   S_D1 = 5'd6,    S_P00 = 5'd7,
                          S_P00A = 5'd8,  S_P01 = 5'd9,   S_P01A = 5'd10, S_P10A = 5'd11,
                          S_P11 = 5'd12,  S_P11A = 5'd13, S_ERR = 5'd14,  S_E = 5'd15,
                          S_K0 = 5'd16,   S_K1 = 5'd17,   S_M00 = 5'd18,  S_M01 = 5'd19,
                          S_M10 = 5'd20,  S_M11 = 5'd21,  S_MA = 5'd22,   S_MB = 5'd23,
                          S_OUT = 5'd24,  S_WAIT = 5'd25;

   logic [16:0] qa_ff, qg_ff, dt_ff;
   logic [19:0] r_ff;
   logic signed [31:0] ang_ff, bias_ff, p00_ff, p01_ff, p10_ff, p11_ff;
   logic signed [31:0] meas_ff, gyro_ff, rate_ff, d_ff, err_ff, e_ff, k0_ff, k1_ff;
   logic signed [31:0] t0_ff, t1_ff, prod_ff;
   logic signed [33:0] d0w_ff;
   logic [4:0] st_ff;
   logic rsp_v_ff;
   logic [63:0] rsp_d_ff;
   logic rsp_load;

   // Shared multiplier and adder operands
   logic signed [31:0] ma, mb, aa, ab;
   logic signed [33:0] aw;
   logic sub;
   logic signed [63:0] mfull, mshift;
   logic signed [31:0] msat, asat;
   logic signed [34:0] asum;

   function automatic logic signed [31:0] sat(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   always_comb begin
      ma = rate_ff; mb = $signed({15'd0, dt_ff}); aa = ang_ff; ab = prod_ff; sub = 1'b0;
      case (st_ff)
         S_RATE: begin aa = gyro_ff; ab = bias_ff; sub = 1'b1; end
         S_D0A: begin aa = $signed({15'd0, qa_ff}); ab = p01_ff; sub = 1'b1; end
         S_D0B: begin ab = p10_ff; sub = 1'b1; end
         S_D1: begin aa = 32'sd0; ab = p11_ff; sub = 1'b1; ma = d_ff; end
         S_P00: begin ma = d_ff; aa = p00_ff; end
         S_P00A: begin ma = d_ff; aa = p00_ff; end
         S_P01: begin ma = d_ff; aa = p01_ff; end
         S_P01A: begin ma = d_ff; aa = p01_ff; end
         S_P10A: begin ma = $signed({15'd0, qg_ff}); aa = p10_ff; end
         S_P11: begin ma = $signed({15'd0, qg_ff}); aa = p11_ff; end
         S_P11A: begin aa = p11_ff; end
         S_ERR: begin aa = meas_ff; ab = ang_ff; sub = 1'b1; end
         S_E: begin aa = $signed({12'd0, r_ff}); ab = p00_ff; end
         S_M00: begin ma = k0_ff; mb = t0_ff; end
         S_M01: begin ma = k0_ff; mb = t1_ff; aa = p00_ff; sub = 1'b1; end
         S_M10: begin ma = k1_ff; mb = t0_ff; aa = p01_ff; sub = 1'b1; end
         S_M11: begin ma = k1_ff; mb = t1_ff; aa = p10_ff; sub = 1'b1; end
         S_MA: begin ma = k0_ff; mb = err_ff; aa = p11_ff; sub = 1'b1; end
         S_MB: begin ma = k1_ff; mb = err_ff; aa = ang_ff; end
         S_OUT: begin aa = bias_ff; end
         S_WAIT: begin aa = gyro_ff; ab = bias_ff; sub = 1'b1; end
         default: ;
      endcase
      mfull = ma * mb;
      mshift = mfull >>> FRAC_BITS;
      msat = sat(mshift);
      // The first difference of d0 is kept exact so that the sum saturates only once.
      aw = (st_ff == S_D0B) ? d0w_ff : {{2{aa[31]}}, aa};
      asum = sub ? ({aw[33], aw} - {{3{ab[31]}}, ab})
                 : ({aw[33], aw} + {{3{ab[31]}}, ab});
      asat = sat({{29{asum[34]}}, asum});
   end

   // Serial restoring divider on magnitudes
   logic div_go, div_busy_ff, div_neg_ff;
   logic [CNT_W-1:0] div_cnt_ff;
   logic [DIV_W-1:0] div_q_ff, div_num;
   logic [32:0] div_rem_ff, div_den_ff, div_try;
   logic signed [31:0] div_n;
   logic signed [DIV_W:0] div_res;
   assign div_n = (st_ff == S_K0) ? p00_ff : p10_ff;
   assign div_num = {(div_n[31] ? 32'd0 - div_n : div_n), {FRAC_BITS{1'b0}}, 1'b0} >> 1;
   assign div_try = {div_rem_ff[31:0], div_q_ff[DIV_W-1]} - div_den_ff;
   assign div_go = (st_ff == S_K0 || st_ff == S_K1) && !div_busy_ff && e_ff != 32'sd0;
   assign div_res = div_neg_ff ? -$signed({1'b0, div_q_ff}) : $signed({1'b0, div_q_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
      end else if (div_go) begin
         div_busy_ff <= 1'b1;
         div_q_ff <= div_num;
         div_rem_ff <= '0;
         div_den_ff <= e_ff[31] ? {1'b0, 32'd0 - e_ff} : {1'b0, e_ff};
         div_neg_ff <= div_n[31] ^ e_ff[31];
         div_cnt_ff <= CNT_W'(DIV_W);
      end else if (div_busy_ff && div_cnt_ff != '0) begin
         if (!div_try[32]) begin
            div_rem_ff <= div_try;
            div_q_ff <= {div_q_ff[DIV_W-2:0], 1'b1};
         end else begin
            div_rem_ff <= {div_rem_ff[31:0], div_q_ff[DIV_W-1]};
            div_q_ff <= {div_q_ff[DIV_W-2:0], 1'b0};
         end
         div_cnt_ff <= div_cnt_ff - 1'b1;
      end else if (div_busy_ff) begin
         div_busy_ff <= 1'b0;
      end
   end

   logic div_done;
   logic signed [31:0] gain;
   assign div_done = div_busy_ff && div_cnt_ff == '0;
   assign gain = sat(64'(div_res));

   assign req_tready = (st_ff == S_IDLE);
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata = rsp_d_ff;
   assign rsp_load = (st_ff == S_WAIT) && (!rsp_v_ff || rsp_tready);

   // Sequencer: most steps use the shared adder, many on the registered product; the gain steps wait on the divider
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; rsp_v_ff <= 1'b0;
         qa_ff <= 17'd131; qg_ff <= 17'd131; r_ff <= 20'd32768; dt_ff <= 17'd655;
         ang_ff <= '0; bias_ff <= '0; p00_ff <= ONE; p01_ff <= '0; p10_ff <= '0; p11_ff <= ONE;
      end else begin
         prod_ff <= msat;
         if (rsp_load) rsp_v_ff <= 1'b1;
         else if (rsp_tready) rsp_v_ff <= 1'b0;
         if (csr_we) begin
            case (csr_index)
               CSR_ANGLE_NOISE: qa_ff <= csr_wdata[16:0];
               CSR_BIAS_NOISE: qg_ff <= csr_wdata[16:0];
               CSR_MEASURE_NOISE: r_ff <= csr_wdata;
               CSR_TIME_STEP: dt_ff <= csr_wdata[16:0];
               default: ;
            endcase
         end
         case (st_ff)
            S_IDLE: if (req_tvalid) begin
               meas_ff <= req_tdata[31:0]; gyro_ff <= req_tdata[63:32]; st_ff <= S_RATE;
            end
            S_RATE: begin rate_ff <= asat; st_ff <= S_AMUL; end
            S_AMUL: st_ff <= S_AADD;
            S_AADD: begin ang_ff <= asat; st_ff <= S_D0A; end
            S_D0A: begin d0w_ff <= asum[33:0]; st_ff <= S_D0B; end
            S_D0B: begin d_ff <= asat; st_ff <= S_P00; end
            S_P00: st_ff <= S_P00A;
            S_P00A: begin p00_ff <= asat; st_ff <= S_D1; end
            S_D1: begin d_ff <= asat; st_ff <= S_P01; end
            S_P01: st_ff <= S_P01A;
            S_P01A: begin p01_ff <= asat; st_ff <= S_P10A; end
            S_P10A: begin p10_ff <= asat; st_ff <= S_P11; end
            S_P11: st_ff <= S_P11A;
            S_P11A: begin p11_ff <= asat; st_ff <= S_ERR; end
            S_ERR: begin err_ff <= asat; t0_ff <= p00_ff; t1_ff <= p01_ff; st_ff <= S_E; end
            S_E: begin e_ff <= asat; st_ff <= S_K0; end
            S_K0: if (e_ff == 32'sd0) begin k0_ff <= '0; st_ff <= S_K1; end
                  else if (div_done) begin k0_ff <= gain; st_ff <= S_K1; end
            S_K1: if (e_ff == 32'sd0) begin k1_ff <= '0; st_ff <= S_M00; end
                  else if (div_done) begin k1_ff <= gain; st_ff <= S_M00; end
            S_M00: st_ff <= S_M01;
            S_M01: begin p00_ff <= asat; st_ff <= S_M10; end
            S_M10: begin p01_ff <= asat; st_ff <= S_M11; end
            S_M11: begin p10_ff <= asat; st_ff <= S_MA; end
            S_MA: begin p11_ff <= asat; st_ff <= S_MB; end
            S_MB: begin ang_ff <= asat; st_ff <= S_OUT; end
            S_OUT: begin bias_ff <= asat; st_ff <= S_WAIT; end
            S_WAIT: if (rsp_load) begin
               rsp_d_ff <= {asat, ang_ff}; st_ff <= S_IDLE;
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready) else $error("took a word while busy");
   a_div_state: assert property (@(posedge clock) disable iff (reset)
      div_busy_ff |-> (st_ff == S_K0 || st_ff == S_K1)) else $error("divider outside gain step");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped");
`endif
endmodule
